FILE: design/cec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_pkg
// Shared types, constants and calendar tables of the epoch converter.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam int ZONE_W  = 17;
  localparam int EPOCH_W = 32;
  localparam int BASE_W  = 30;
  localparam int ACC_W   = 35;
  localparam int DAYS_W  = 16;
  localparam int YEAR_W  = 12;
  localparam int YOFF_W  = 7;

  localparam logic [BASE_W-1:0] EPOCH_2000   = 30'd946684800;
  localparam logic [ZONE_W-1:0] ZONE_RESET   = 17'd28800;
  localparam logic [BASE_W-1:0] BASE_RESET   = EPOCH_2000 - BASE_W'(ZONE_RESET);
  localparam logic [YEAR_W-1:0] YEAR_BASE    = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_MAX     = 12'd99;
  localparam logic [DAYS_W-1:0] DAYS_CENTURY = 16'd36525;
  localparam logic [DAYS_W-1:0] DAYS_QUAD    = 16'd1461;
  localparam logic [3:0]        LAST_MONTH   = 4'd12;

  // reciprocal divide: q = (n * magic) >> shift, exact for any 32-bit n
  localparam logic [EPOCH_W-1:0] MAGIC_60 = 32'h8888_8889;
  localparam logic [EPOCH_W-1:0] MAGIC_24 = 32'hAAAA_AAAB;
  localparam int                 SHR_60   = 37;
  localparam int                 SHR_24   = 36;

  typedef enum logic {
    CMD_TO_EPOCH = 1'b0,
    CMD_TO_CAL   = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    OP_IDLE       = 4'd0,
    OP_ENC_DAYS   = 4'd1,
    OP_ENC_HOUR   = 4'd2,
    OP_ENC_MIN    = 4'd3,
    OP_ENC_SEC    = 4'd4,
    OP_ENC_BASE   = 4'd5,
    OP_DEC_SUB    = 4'd6,
    OP_DIV_STEP   = 4'd7,
    OP_DIV_NEXT   = 4'd8,
    OP_YEAR_CHECK = 4'd9,
    OP_YEAR_QUAD  = 4'd10,
    OP_YEAR_ONE   = 4'd11,
    OP_MONTH      = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    DIV_SEC  = 2'd0,
    DIV_MIN  = 2'd1,
    DIV_HOUR = 2'd2
  } div_sel_e;

  typedef struct packed {
    op_e      op;
    div_sel_e sel;
    logic     load_in;
    logic     load_out;
  } cec_ctrl_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [EPOCH_W-1:0] epoch_in;
    logic [YEAR_W-1:0] year_in;
    logic [3:0]        month_in;
    logic [4:0]        day_in;
    logic [4:0]        hour_in;
    logic [5:0]        minute_in;
    logic [5:0]        second_in;
  } cec_in_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_out;
    logic [YOFF_W-1:0]  year_offset_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [4:0]         hour_out;
    logic [5:0]         minute_out;
    logic [5:0]         second_out;
    logic               range_error;
  } cec_out_t;

  // days before the first of month m; zero and thirteen up saturate
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13,
      4'd14,
      4'd15:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // days in month m of a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] div_divisor(input div_sel_e s);
    logic [6:0] r;
    case (s)
      DIV_HOUR: r = 7'd24;
      default:  r = 7'd60;
    endcase
    return r;
  endfunction

  function automatic logic [EPOCH_W-1:0] div_magic(input div_sel_e s);
    logic [EPOCH_W-1:0] r;
    case (s)
      DIV_HOUR: r = MAGIC_24;
      default:  r = MAGIC_60;
    endcase
    return r;
  endfunction

endpackage

FILE: design/cec_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_in_if
// Request channel of the epoch converter: valid/ready and one request beat.
// ----------------------------------------------------------------------------
interface cec_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] epoch_in;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  modport source (
    output valid, cmd, epoch_in, year_in, month_in, day_in, hour_in, minute_in,
           second_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, epoch_in, year_in, month_in, day_in, hour_in, minute_in,
           second_in,
    output ready
  );
endinterface

FILE: design/cec_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_out_if
// Result channel of the epoch converter: valid/ready and one result beat.
// ----------------------------------------------------------------------------
interface cec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_out;
  logic [6:0]  year_offset_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic        range_error;

  modport source (
    output valid, epoch_out, year_offset_out, month_out, day_out, hour_out,
           minute_out, second_out, range_error,
    input  ready
  );

  modport sink (
    input  valid, epoch_out, year_offset_out, month_out, day_out, hour_out,
           minute_out, second_out, range_error,
    output ready
  );
endinterface

FILE: design/cec_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_ctrl
// Sequencer of the converter: steps the datapath through encode or decode.
// ----------------------------------------------------------------------------
module cec_ctrl import cec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  cmd_e      in_cmd_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cec_ctrl_t dp_cmd_o,
  input  logic      dp_stop_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ENC_DAYS = 4'd1;
  localparam logic [3:0] S_ENC_HOUR = 4'd2;
  localparam logic [3:0] S_ENC_MIN  = 4'd3;
  localparam logic [3:0] S_ENC_SEC  = 4'd4;
  localparam logic [3:0] S_ENC_BASE = 4'd5;
  localparam logic [3:0] S_DSUB     = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DNEXT    = 4'd8;
  localparam logic [3:0] S_YCHK     = 4'd9;
  localparam logic [3:0] S_QUAD     = 4'd10;
  localparam logic [3:0] S_YEAR     = 4'd11;
  localparam logic [3:0] S_MONTH    = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]       state_q, state_d;
  div_sel_e         sel_q, sel_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    dp_cmd_o    = '{op: OP_IDLE, sel: sel_q, load_in: 1'b0, load_out: 1'b0};

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.load_in = 1'b1;
          state_d = (in_cmd_i == CMD_TO_EPOCH) ? S_ENC_DAYS : S_DSUB;
        end
      end
      S_ENC_DAYS: begin
        dp_cmd_o.op = OP_ENC_DAYS;
        state_d = S_ENC_HOUR;
      end
      S_ENC_HOUR: begin
        dp_cmd_o.op = OP_ENC_HOUR;
        state_d = S_ENC_MIN;
      end
      S_ENC_MIN: begin
        dp_cmd_o.op = OP_ENC_MIN;
        state_d = S_ENC_SEC;
      end
      S_ENC_SEC: begin
        dp_cmd_o.op = OP_ENC_SEC;
        state_d = S_ENC_BASE;
      end
      S_ENC_BASE: begin
        dp_cmd_o.op = OP_ENC_BASE;
        state_d = S_DONE;
      end
      S_DSUB: begin
        dp_cmd_o.op = OP_DEC_SUB;
        if (dp_stop_i) begin
          state_d = S_DONE;
        end else begin
          sel_d   = DIV_SEC;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        dp_cmd_o.op = OP_DIV_STEP;
        state_d = S_DNEXT;
      end
      S_DNEXT: begin
        dp_cmd_o.op = OP_DIV_NEXT;
        case (sel_q)
          DIV_SEC: begin
            sel_d   = DIV_MIN;
            state_d = S_DIV;
          end
          DIV_MIN: begin
            sel_d   = DIV_HOUR;
            state_d = S_DIV;
          end
          default: begin
            state_d = S_YCHK;
          end
        endcase
      end
      S_YCHK: begin
        dp_cmd_o.op = OP_YEAR_CHECK;
        state_d = dp_stop_i ? S_DONE : S_QUAD;
      end
      S_QUAD: begin
        dp_cmd_o.op = OP_YEAR_QUAD;
        if (dp_stop_i) state_d = S_YEAR;
      end
      S_YEAR: begin
        dp_cmd_o.op = OP_YEAR_ONE;
        if (dp_stop_i) state_d = S_MONTH;
      end
      S_MONTH: begin
        dp_cmd_o.op = OP_MONTH;
        if (dp_stop_i) state_d = S_DONE;
      end
      S_DONE: begin
        // output register free or draining this cycle
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= DIV_SEC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/cec_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_dp
// Datapath: constant-multiply encoder, reciprocal divider, year/month stepper.
// ----------------------------------------------------------------------------
module cec_dp import cec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ZONE_W-1:0] cfg_wdata_i,
  input  cec_ctrl_t         cmd_i,
  output logic              stop_o,
  input  cec_in_t           in_i,
  output cec_out_t          out_o
);

  cec_in_t            in_q, in_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [EPOCH_W-1:0] num_q, num_d;
  logic [EPOCH_W-1:0] quo_q, quo_d;
  logic [DAYS_W-1:0]  days_q, days_d;
  logic [YOFF_W-1:0]  yoff_q, yoff_d;
  logic [3:0]         mon_q, mon_d;
  logic [4:0]         hour_q, hour_d;
  logic [5:0]         min_q, min_d;
  logic [5:0]         sec_q, sec_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               err_q, err_d;
  logic [BASE_W-1:0]  base_q;
  cec_out_t           out_q, out_d;

  // encode helpers
  logic [YEAR_W-1:0]       y_full;
  logic [YOFF_W-1:0]       y_off;
  logic                    enc_leap;
  logic [DAYS_W-1:0]       enc_sum;
  logic signed [ACC_W-1:0] acc_x24, acc_x60, enc_e;

  // decode helpers
  logic [EPOCH_W:0]     dec_diff;
  logic [2*EPOCH_W-1:0] div_prod;
  logic [EPOCH_W-1:0]   div_quo;
  logic [6:0]           div_v;
  logic [7:0]           div_rem;
  logic                 dec_leap;
  logic [8:0]           year_len;
  logic [4:0]           mon_len;

  always_comb begin
    y_full   = (in_q.year_in >= YEAR_BASE) ? in_q.year_in - YEAR_BASE : in_q.year_in;
    y_off    = y_full[YOFF_W-1:0];
    enc_leap = (y_off[1:0] == 2'b00);
    enc_sum  = DAYS_W'(in_q.day_in) + DAYS_W'(month_start(in_q.month_in))
             + DAYS_W'(enc_leap && (in_q.month_in > 4'd2))
             + DAYS_W'(y_off) * DAYS_W'(365)
             + DAYS_W'((8'(y_off) + 8'd3) >> 2);
    acc_x24  = (acc_q <<< 4) + (acc_q <<< 3);
    acc_x60  = (acc_q <<< 6) - (acc_q <<< 2);
    enc_e    = acc_q + $signed(ACC_W'(base_q));

    dec_diff = {1'b0, in_q.epoch_in} - (EPOCH_W + 1)'(base_q);
    div_v    = div_divisor(cmd_i.sel);
    div_prod = (2*EPOCH_W)'(num_q) * (2*EPOCH_W)'(div_magic(cmd_i.sel));
    div_quo  = (cmd_i.sel == DIV_HOUR) ? EPOCH_W'(div_prod[2*EPOCH_W-1:SHR_24])
                                       : EPOCH_W'(div_prod[2*EPOCH_W-1:SHR_60]);
    // remainder is below 60, so the low byte of n - q*d carries it
    div_rem  = num_q[7:0] - 8'(quo_q[7:0] * 8'(div_v));
    dec_leap = (yoff_q[1:0] == 2'b00);
    year_len = dec_leap ? 9'd366 : 9'd365;
    mon_len  = month_len(mon_q) + 5'(dec_leap && (mon_q == 4'd2));
  end

  always_comb begin
    case (cmd_i.op)
      OP_DEC_SUB:    stop_o = dec_diff[EPOCH_W];
      OP_YEAR_CHECK: stop_o = (days_q >= DAYS_CENTURY);
      OP_YEAR_QUAD:  stop_o = (days_q < DAYS_QUAD);
      OP_YEAR_ONE:   stop_o = (days_q < DAYS_W'(year_len));
      OP_MONTH:      stop_o = (days_q < DAYS_W'(mon_len)) || (mon_q >= LAST_MONTH);
      default:       stop_o = 1'b0;
    endcase
  end

  always_comb begin
    in_d    = in_q;
    acc_d   = acc_q;
    num_d   = num_q;
    quo_d   = quo_q;
    days_d  = days_q;
    yoff_d  = yoff_q;
    mon_d   = mon_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    epoch_d = epoch_q;
    err_d   = err_q;
    out_d   = out_q;

    if (cmd_i.load_in) begin
      in_d    = in_i;
      yoff_d  = '0;
      mon_d   = 4'd1;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      epoch_d = '0;
      err_d   = 1'b0;
    end

    case (cmd_i.op)
      OP_ENC_DAYS: begin
        if (y_full > YEAR_MAX) err_d = 1'b1;
        acc_d = $signed(ACC_W'(enc_sum)) - 1;
      end
      OP_ENC_HOUR: acc_d = acc_x24 + $signed(ACC_W'(in_q.hour_in));
      OP_ENC_MIN:  acc_d = acc_x60 + $signed(ACC_W'(in_q.minute_in));
      OP_ENC_SEC:  acc_d = acc_x60 + $signed(ACC_W'(in_q.second_in));
      OP_ENC_BASE: begin
        // before local 2000, or past 32 bits
        if (acc_q[ACC_W-1] || (enc_e[ACC_W-1:EPOCH_W] != '0)) err_d = 1'b1;
        epoch_d = enc_e[EPOCH_W-1:0];
      end
      OP_DEC_SUB: begin
        if (dec_diff[EPOCH_W]) err_d = 1'b1;
        num_d = dec_diff[EPOCH_W-1:0];
      end
      OP_DIV_STEP: begin
        quo_d = div_quo;
      end
      OP_DIV_NEXT: begin
        // quotient becomes the dividend of the next pass
        num_d = quo_q;
        case (cmd_i.sel)
          DIV_SEC: begin
            sec_d = div_rem[5:0];
          end
          DIV_MIN: begin
            min_d = div_rem[5:0];
          end
          default: begin
            hour_d = div_rem[4:0];
            days_d = quo_q[DAYS_W-1:0];
          end
        endcase
      end
      OP_YEAR_CHECK: begin
        if (days_q >= DAYS_CENTURY) err_d = 1'b1;
      end
      OP_YEAR_QUAD: begin
        if (days_q >= DAYS_QUAD) begin
          days_d = days_q - DAYS_QUAD;
          yoff_d = yoff_q + YOFF_W'(4);
        end
      end
      OP_YEAR_ONE: begin
        if (days_q >= DAYS_W'(year_len)) begin
          days_d = days_q - DAYS_W'(year_len);
          yoff_d = yoff_q + 1'b1;
        end
      end
      OP_MONTH: begin
        if (!((days_q < DAYS_W'(mon_len)) || (mon_q >= LAST_MONTH))) begin
          days_d = days_q - DAYS_W'(mon_len);
          mon_d  = mon_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cmd_i.load_out) begin
      out_d = '0;
      out_d.range_error = err_q;
      if (!err_q) begin
        if (in_q.cmd == CMD_TO_EPOCH) begin
          out_d.epoch_out = epoch_q;
        end else begin
          out_d.year_offset_out = yoff_q;
          out_d.month_out       = mon_q;
          out_d.day_out         = days_q[4:0] + 5'd1;
          out_d.hour_out        = hour_q;
          out_d.minute_out      = min_q;
          out_d.second_out      = sec_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= 1'b0;
      base_q <= BASE_RESET;
    end else begin
      err_q <= err_d;
      if (cfg_we_i) begin
        base_q <= EPOCH_2000 - BASE_W'($signed(cfg_wdata_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    acc_q   <= acc_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    days_q  <= days_d;
    yoff_q  <= yoff_d;
    mon_q   <= mon_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    epoch_q <= epoch_d;
    out_q   <= out_d;
  end

  assign out_o = out_q;

endmodule

FILE: design/calendar_epoch_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_epoch_converter
// Calendar fields to epoch seconds and back, years 2000 to 2099, with zone.
// ----------------------------------------------------------------------------
// Calendar to epoch steps days, hour, minute and second, then adds the base. Epoch to
//   calendar subtracts the base and ends with a range error when the epoch is before it.
// Decode runs /60 /60 /24 as reciprocal multiplies (a multiply and a remainder step
//   each), checks for past 2099, then up to 24 four-year, 3 year and 11 month subtract steps.
// Throughput: one item in flight; next beat taken the cycle after the result
//   registers. Reset: async, active low; idle, no result, zone offset 28800.
module calendar_epoch_converter import cec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ZONE_W-1:0] cfg_wdata_i,
  cec_in_if.sink            in_i,
  cec_out_if.source         out_o
);

  cec_ctrl_t dp_cmd;
  logic      dp_stop;
  cec_in_t   in_pay;
  cec_out_t  out_pay;

  assign in_pay.cmd       = cmd_e'(in_i.cmd);
  assign in_pay.epoch_in  = in_i.epoch_in;
  assign in_pay.year_in   = in_i.year_in;
  assign in_pay.month_in  = in_i.month_in;
  assign in_pay.day_in    = in_i.day_in;
  assign in_pay.hour_in   = in_i.hour_in;
  assign in_pay.minute_in = in_i.minute_in;
  assign in_pay.second_in = in_i.second_in;

  cec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_pay.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_stop_i   (dp_stop)
  );

  cec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .stop_o      (dp_stop),
    .in_i        (in_pay),
    .out_o       (out_pay)
  );

  assign out_o.epoch_out       = out_pay.epoch_out;
  assign out_o.year_offset_out = out_pay.year_offset_out;
  assign out_o.month_out       = out_pay.month_out;
  assign out_o.day_out         = out_pay.day_out;
  assign out_o.hour_out        = out_pay.hour_out;
  assign out_o.minute_out      = out_pay.minute_out;
  assign out_o.second_out      = out_pay.second_out;
  assign out_o.range_error     = out_pay.range_error;

endmodule

FILE: design/cec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_checker
// Port-level checks of the epoch converter, bound to the top level.
// ----------------------------------------------------------------------------
module cec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] epoch_out_i,
  input logic [6:0]  year_offset_out_i,
  input logic [3:0]  month_out_i,
  input logic [4:0]  day_out_i,
  input logic [4:0]  hour_out_i,
  input logic [5:0]  minute_out_i,
  input logic [5:0]  second_out_i,
  input logic        range_error_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(epoch_out_i)
      && $stable(year_offset_out_i) && $stable(month_out_i) && $stable(day_out_i)
      && $stable(hour_out_i) && $stable(minute_out_i) && $stable(second_out_i)
      && $stable(range_error_i))
    else $error("result beat changed while stalled");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && range_error_i |-> epoch_out_i == 32'd0
      && year_offset_out_i == 7'd0 && month_out_i == 4'd0 && day_out_i == 5'd0
      && hour_out_i == 5'd0 && minute_out_i == 6'd0 && second_out_i == 6'd0)
    else $error("error beat carries values");

  a_cal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && month_out_i != 4'd0 |-> epoch_out_i == 32'd0
      && month_out_i <= 4'd12 && day_out_i != 5'd0 && year_offset_out_i <= 7'd99
      && hour_out_i <= 5'd23 && minute_out_i <= 6'd59 && second_out_i <= 6'd59)
    else $error("calendar beat out of range");

endmodule

bind calendar_epoch_converter cec_checker u_cec_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .epoch_out_i       (out_o.epoch_out),
  .year_offset_out_i (out_o.year_offset_out),
  .month_out_i       (out_o.month_out),
  .day_out_i         (out_o.day_out),
  .hour_out_i        (out_o.hour_out),
  .minute_out_i      (out_o.minute_out),
  .second_out_i      (out_o.second_out),
  .range_error_i     (out_o.range_error)
);
